>>> design/tsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsa_pkg;

    // Field widths
    localparam int TID_W   = 31;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int SLOT_OW = 4;
    localparam int ADDR_W  = 32;
    localparam int MT_W    = 5;
    localparam int STRD_W  = 20;
    localparam int LIVE_OW = 5;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 2;

    // Default table size
    localparam int MAX_SLOTS_DEF = 16;

    // Register reset values
    localparam logic [MT_W-1:0]   MAX_THR_RST = 5'd16;
    localparam logic [ADDR_W-1:0] INIT_SP_RST = 32'd0;
    localparam logic [STRD_W-1:0] STRIDE_RST  = 20'd0;

    localparam logic [TID_W-1:0] TID_MAX = {TID_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2,
        ST_RSVD   = 2'd3
    } t_status;

    typedef enum logic [CIDX_W-1:0] {
        CFG_MAX_THREADS  = 2'd0,
        CFG_INITIAL_SP   = 2'd1,
        CFG_STACK_STRIDE = 2'd2,
        CFG_RSVD         = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [TID_W-1:0] tid;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [TID_W-1:0]   tid_out;
        logic [SLOT_OW-1:0] slot;
        logic [ADDR_W-1:0]  stack_begin;
        logic               last_gone;
        logic [LIVE_OW-1:0] live_count;
    } t_rsp;

endpackage

`default_nettype wire

>>> design/tsa_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Iterative remainder unit: two dividend bits per cycle, restoring form.
module tsa_div (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire [tsa_pkg::TID_W-1:0]  i_dividend,
    input  wire [tsa_pkg::MT_W-1:0]   i_divisor,
    output logic                      o_done,
    output logic [tsa_pkg::MT_W-1:0]  o_rem
);
    import tsa_pkg::*;

    localparam int DVD_W   = TID_W + 1;
    localparam int STEPS   = DVD_W / 2;
    localparam int CNT_W   = $clog2(STEPS);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [MT_W-1:0]   r_rem;
    logic [MT_W-1:0]   r_div;

    logic [MT_W:0]     w_try1;
    logic [MT_W:0]     w_try2;
    logic [MT_W-1:0]   w_rem1;
    logic [MT_W-1:0]   n_rem;

    // Two compare-subtract steps per cycle
    always_comb begin
        w_try1 = {r_rem, r_dvd[DVD_W-1]};
        if (w_try1 >= {1'b0, r_div}) begin
            w_rem1 = MT_W'(w_try1 - {1'b0, r_div});
        end else begin
            w_rem1 = w_try1[MT_W-1:0];
        end
        w_try2 = {w_rem1, r_dvd[DVD_W-2]};
        if (w_try2 >= {1'b0, r_div}) begin
            n_rem = MT_W'(w_try2 - {1'b0, r_div});
        end else begin
            n_rem = w_try2[MT_W-1:0];
        end
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift dividend, advance remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {1'b0, i_dividend};
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-3:0], 2'b00};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

>>> design/thread_slot_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Thread slot allocator. Takes one request at a time (create, lookup, delete)
// and returns one response per request. Every request but a create on a
// full table first reduces a tid modulo the clamped max_threads in a shared
// two-bits-per-cycle remainder unit. A lookup or delete then reads the tid
// table (a memory with registered read) in S_LOOK and answers from S_CHECK.
// A create walks the slot valid bits one slot per cycle from the running tid
// counter, probing 1 to 2*MAX_SLOTS slots, then forms the stack start with
// one multiply and one subtract. A create on a full table goes straight to
// the response state with status FULL. The response sits in an output
// register; a new request is taken once the previous one is handed to that
// register.
module thread_slot_allocator #(
    parameter int MAX_SLOTS = tsa_pkg::MAX_SLOTS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  tsa_pkg::t_req              i_in_req,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output tsa_pkg::t_rsp              o_out_rsp,
    input  wire                        i_cfg_we,
    input  wire [tsa_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  wire [tsa_pkg::CFG_W-1:0]   i_cfg_data
);
    import tsa_pkg::*;

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int LIVE_W = $clog2(MAX_SLOTS + 1);
    localparam int STEP_W = $clog2(2 * MAX_SLOTS);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DIV   = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_SUB   = 8'b0001_0000,
        S_LOOK  = 8'b0010_0000,
        S_CHECK = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } t_state;

    t_state              r_state;
    t_state              n_state;

    // Configuration
    logic [MT_W-1:0]     r_max_thr;
    logic [ADDR_W-1:0]   r_init_sp;
    logic [STRD_W-1:0]   r_stride;

    // Table state
    logic [MAX_SLOTS-1:0] r_valid;
    logic [TID_W-1:0]     mem_tid [MAX_SLOTS];
    logic [TID_W-1:0]     r_rd_tid;
    logic [TID_W-1:0]     r_next_tid;
    logic [LIVE_W-1:0]    r_live;

    // Request context
    logic                r_create;
    logic                r_delete;
    logic [TID_W-1:0]    r_tid;
    logic [TID_W-1:0]    r_t;
    logic [SLOT_W-1:0]   r_s;
    logic [STEP_W-1:0]   r_step;
    logic [ADDR_W-1:0]   r_prod;
    t_rsp                r_res;
    t_rsp                r_out;
    logic                r_out_valid;

    logic                w_accept;
    logic                w_is_create;
    logic                w_full;
    logic                w_div_start;
    logic [TID_W-1:0]    w_dividend;
    logic                w_div_done;
    logic [MT_W-1:0]     w_rem;
    logic [MT_W-1:0]     w_m;
    logic [SLOT_W+MT_W-1:0] w_rem_ext;
    logic [SLOT_W+SLOT_OW-1:0] w_slot_ext;
    logic [LIVE_W+LIVE_OW-1:0] w_live_ext;
    logic                w_free;
    logic                w_last_step;
    logic                w_s_wrap;
    logic                w_present;
    logic                w_claim;
    logic                w_out_load;

    // Clamp the configured divisor to 1..MAX_SLOTS
    always_comb begin
        priority if (r_max_thr == '0) begin
            w_m = MT_W'(1);
        end else if (32'(r_max_thr) > 32'(MAX_SLOTS)) begin
            w_m = MT_W'(MAX_SLOTS);
        end else begin
            w_m = r_max_thr;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_is_create = (i_in_req.operation == OP_CREATE);
    assign w_full      = (32'(r_live) >= 32'(w_m));
    assign w_div_start = w_accept && !(w_is_create && w_full);
    assign w_dividend  = w_is_create ? r_next_tid : i_in_req.tid;

    assign w_rem_ext   = {{SLOT_W{1'b0}}, w_rem};
    assign w_slot_ext  = {{SLOT_OW{1'b0}}, r_s};
    assign w_live_ext  = {{LIVE_OW{1'b0}}, r_live};

    assign w_free      = !r_valid[r_s];
    assign w_last_step = (r_step == STEP_W'(2 * MAX_SLOTS - 1));
    assign w_s_wrap    = (32'(r_s) + 32'd1 == 32'(w_m)) || (r_t == TID_MAX);
    assign w_present   = r_valid[r_s] && (r_rd_tid == r_tid);
    assign w_claim     = (r_state == S_SCAN) && w_free;
    assign w_out_load  = (r_state == S_RESP) && (!r_out_valid || i_out_ready);

    tsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_m),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_is_create && w_full) ? S_RESP : S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = r_create ? S_SCAN : S_LOOK;
                end
            end
            S_SCAN: begin
                if (w_free) begin
                    n_state = S_MUL;
                end else if (w_last_step) begin
                    n_state = S_RESP;
                end
            end
            S_MUL:   n_state = S_SUB;
            S_SUB:   n_state = S_RESP;
            S_LOOK:  n_state = S_CHECK;
            S_CHECK: n_state = S_RESP;
            S_RESP: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, table bookkeeping and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_next_tid  <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
            r_max_thr   <= MAX_THR_RST;
            r_init_sp   <= INIT_SP_RST;
            r_stride    <= STRIDE_RST;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_THREADS:  r_max_thr <= i_cfg_data[MT_W-1:0];
                    CFG_INITIAL_SP:   r_init_sp <= i_cfg_data[ADDR_W-1:0];
                    CFG_STACK_STRIDE: r_stride  <= i_cfg_data[STRD_W-1:0];
                    default: ;
                endcase
            end

            // Claim a free slot on create
            if (w_claim) begin
                r_valid[r_s] <= 1'b1;
                r_next_tid   <= r_t;
                r_live       <= r_live + LIVE_W'(1);
            end

            // Free the slot on a matching delete
            if ((r_state == S_CHECK) && w_present && r_delete) begin
                r_valid[r_s] <= 1'b0;
                if (r_live != '0) begin
                    r_live <= r_live - LIVE_W'(1);
                end
            end

            // Drop the response once taken, refill from the sequencer
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Tid table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_claim) begin
            mem_tid[r_s] <= r_t;
        end
        r_rd_tid <= mem_tid[r_s];
    end

    // Request datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_create <= w_is_create;
                    r_delete <= (i_in_req.operation == OP_DELETE);
                    r_tid    <= i_in_req.tid;
                    r_t      <= r_next_tid;
                    r_res    <= '{status: ST_FULL, default: '0};
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_s    <= w_rem_ext[SLOT_W-1:0];
                    r_step <= '0;
                end
            end
            S_SCAN: begin
                if (w_free) begin
                    r_res <= '{status: ST_OK, tid_out: r_t,
                               slot: w_slot_ext[SLOT_OW-1:0], default: '0};
                end else if (!w_last_step) begin
                    // Advance to the next tid and its slot
                    r_t    <= (r_t == TID_MAX) ? '0 : r_t + 1'b1;
                    r_s    <= w_s_wrap ? '0 : r_s + 1'b1;
                    r_step <= r_step + 1'b1;
                end
            end
            S_MUL: begin
                r_prod <= ADDR_W'(r_stride) * ADDR_W'(r_s);
            end
            S_SUB: begin
                r_res.stack_begin <= r_init_sp - r_prod;
            end
            S_LOOK: ;
            S_CHECK: begin
                r_res <= '{status: (w_present ? ST_OK : ST_ABSENT),
                           tid_out: r_tid,
                           slot: w_slot_ext[SLOT_OW-1:0],
                           last_gone: (w_present && r_delete && (r_live == LIVE_W'(1))),
                           default: '0};
            end
            S_RESP: begin
                if (w_out_load) begin
                    r_out <= {r_res[$bits(t_rsp)-1:LIVE_OW], w_live_ext[LIVE_OW-1:0]};
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // Live count never exceeds the table size
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_live) <= 32'(MAX_SLOTS))
        else $error("live count above table size");

    // A claim adds exactly one live entry
    a_claim_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_claim |=> r_live == $past(r_live) + LIVE_W'(1))
        else $error("claim did not bump live count");

    // The remainder unit finishes only while the sequencer waits on it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("remainder done outside divide phase");

    // A response appears only from the response phase
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESP))
        else $error("response raised outside response phase");

endmodule

`default_nettype wire
